[rtl/pwmc_pkg.sv]
// Shared types and constants for the PWM period and duty calculator.
// No dependencies.
`default_nettype none
package pwmc_pkg;
	localparam int unsigned PRESCALER_MAX      = 65535;
	localparam int unsigned NARROW_COUNTER_MAX = 65535;
	localparam int unsigned DEAD_TIME_MAX      = 255;
	localparam int unsigned FRAC_BITS          = 16;
	localparam int unsigned DIV_W              = 32;
	localparam int unsigned PSC_W              = 17;

	localparam logic [1:0] REG_TIMER_CLOCK    = 2'd0;
	localparam logic [1:0] REG_COUNTER_WIDE   = 2'd1;
	localparam logic [1:0] REG_ADVANCED_TIMER = 2'd2;

	typedef struct packed {
		logic [31:0] frequency_hz;
		logic [16:0] duty;
		logic [31:0] dead_time;
	} req_t;

	typedef struct packed {
		logic        status;
		logic [15:0] prescale_minus_one;
		logic [31:0] reload_value;
		logic [31:0] compare_value;
		logic [7:0]  dead_time_ticks;
	} rsp_t;

	typedef struct packed {
		logic             status;
		logic [31:0]      freq;
		logic [16:0]      duty;
		logic             wide;
		logic [7:0]       dt;
		logic [31:0]      clk_hz;
		logic [PSC_W-1:0] divider;
	} ctx_t;
endpackage
`default_nettype wire

[rtl/pwmc_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with item context.
// Depends on pwmc_pkg.
`default_nettype none
module pwmc_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       en,
	input  wire logic                       in_v,
	input  wire logic [pwmc_pkg::DIV_W-1:0] dividend,
	input  wire logic [pwmc_pkg::DIV_W-1:0] divisor,
	input  wire pwmc_pkg::ctx_t             in_ctx,
	output logic                            out_v,
	output logic [pwmc_pkg::DIV_W-1:0]      quotient,
	output pwmc_pkg::ctx_t                  out_ctx
);
	import pwmc_pkg::*;

	logic             v_s [0:DIV_W];
	logic [DIV_W-1:0] n_s [0:DIV_W];
	logic [DIV_W-1:0] d_s [0:DIV_W];
	logic [DIV_W-1:0] r_s [0:DIV_W];
	logic [DIV_W-1:0] q_s [0:DIV_W];
	ctx_t             c_s [0:DIV_W];

	always_comb begin
		v_s[0] = in_v;
		n_s[0] = dividend;
		d_s[0] = divisor;
		r_s[0] = '0;
		q_s[0] = '0;
		c_s[0] = in_ctx;
	end

	for (genvar k = 1; k <= DIV_W; k++) begin : g_stage
		logic [DIV_W:0] sh;
		logic           ge;
		always_comb begin
			sh = {r_s[k-1], n_s[k-1][DIV_W-1]};
			ge = sh >= {1'b0, d_s[k-1]};
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_s[k-1];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				n_s[k] <= {n_s[k-1][DIV_W-2:0], 1'b0};
				d_s[k] <= d_s[k-1];
				r_s[k] <= ge ? DIV_W'(sh - {1'b0, d_s[k-1]}) : sh[DIV_W-1:0];
				q_s[k] <= {q_s[k-1][DIV_W-2:0], ge};
				c_s[k] <= c_s[k-1];
			end
		end
	end

	assign out_v    = v_s[DIV_W];
	assign quotient = q_s[DIV_W];
	assign out_ctx  = c_s[DIV_W];
endmodule
`default_nettype wire

[rtl/pwm_period_duty_calc_core.sv]
// Top level: prescaler, reload, compare and dead time for one PWM request.
// Depends on pwmc_pkg and pwmc_div.
//  channel | handshake            | payload
//  req     | req_valid/req_stall  | req (frequency_hz, duty, dead_time)
//  rsp     | rsp_valid/rsp_stall  | rsp (status, prescale, reload, compare, dead time)
//  cfg     | cfg_valid/cfg_ready  | cfg_index, cfg_data
// One item per cycle when no result is held; stages: entry, three 32-stage dividers
// (clock/frequency, prescaler choice after it, clock/prescaler, ticks/frequency),
// clamp, multiply, output. Reset clears valid bits and loads the register defaults.
// A held result freezes the whole pipeline; req_stall follows it.
`default_nettype none
module pwm_period_duty_calc_core (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire pwmc_pkg::req_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output pwmc_pkg::rsp_t      rsp,
	input  wire logic           cfg_valid,
	output logic                cfg_ready,
	input  wire logic [1:0]     cfg_index,
	input  wire logic [31:0]    cfg_data
);
	import pwmc_pkg::*;

	localparam logic [32:0] NARROW_LIM1 = 33'(NARROW_COUNTER_MAX) + 33'd1;
	localparam logic [32:0] WIDE_LIM1   = 33'h1_0000_0000;
	localparam logic [32:0] PSC_TOP     = 33'(PRESCALER_MAX) + 33'd1;

	logic [31:0] clk_hz_q;
	logic        wide_q;
	logic        adv_q;
	logic        en;

	assign cfg_ready = 1'b1;
	assign en        = !(rsp_valid && rsp_stall);
	assign req_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clk_hz_q <= 32'd160000000;
			wide_q   <= 1'b0;
			adv_q    <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_TIMER_CLOCK:    clk_hz_q <= cfg_data;
				REG_COUNTER_WIDE:   wide_q   <= cfg_data[0];
				REG_ADVANCED_TIMER: adv_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// entry
	ctx_t        ctx_in;
	logic [15:0] dt_int;
	always_comb begin
		dt_int         = req.dead_time[31:FRAC_BITS];
		ctx_in.status  = req.frequency_hz == '0;
		ctx_in.freq    = req.frequency_hz;
		ctx_in.duty    = req.duty;
		ctx_in.wide    = wide_q;
		ctx_in.dt      = !adv_q ? 8'd0 :
			(dt_int > 16'(DEAD_TIME_MAX)) ? 8'(DEAD_TIME_MAX) : dt_int[7:0];
		ctx_in.clk_hz  = clk_hz_q;
		ctx_in.divider = '0;
	end

	logic v_s1;
	ctx_t ctx_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= req_valid;
	end
	always_ff @(posedge clk) begin
		if (en) ctx_s1 <= ctx_in;
	end

	logic        a_v;
	logic [31:0] a_q;
	ctx_t        a_ctx;
	pwmc_div u_div_a (
		.clk, .arst_n, .en,
		.in_v(v_s1), .dividend(ctx_s1.clk_hz), .divisor(ctx_s1.freq), .in_ctx(ctx_s1),
		.out_v(a_v), .quotient(a_q), .out_ctx(a_ctx)
	);

	// prescaler choice
	logic [32:0] nsum;
	logic [32:0] ndiv;
	ctx_t        ctx_b;
	always_comb begin
		nsum  = {1'b0, a_q} + 33'(NARROW_COUNTER_MAX);
		ndiv  = nsum / NARROW_LIM1;
		ctx_b = a_ctx;
		if (a_ctx.wide || ndiv == '0) ctx_b.divider = PSC_W'(1);
		else if (ndiv > PSC_TOP)      ctx_b.divider = PSC_TOP[PSC_W-1:0];
		else                          ctx_b.divider = ndiv[PSC_W-1:0];
	end

	logic v_s2;
	ctx_t ctx_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= a_v;
	end
	always_ff @(posedge clk) begin
		if (en) ctx_s2 <= ctx_b;
	end

	logic        b_v;
	logic [31:0] b_q;
	ctx_t        b_ctx;
	pwmc_div u_div_b (
		.clk, .arst_n, .en,
		.in_v(v_s2), .dividend(ctx_s2.clk_hz), .divisor(32'(ctx_s2.divider)), .in_ctx(ctx_s2),
		.out_v(b_v), .quotient(b_q), .out_ctx(b_ctx)
	);

	logic        c_v;
	logic [31:0] c_q;
	ctx_t        c_ctx;
	pwmc_div u_div_c (
		.clk, .arst_n, .en,
		.in_v(b_v), .dividend(b_q), .divisor(b_ctx.freq), .in_ctx(b_ctx),
		.out_v(c_v), .quotient(c_q), .out_ctx(c_ctx)
	);

	// period clamp
	logic [32:0] lim1;
	logic [32:0] per;
	always_comb begin
		lim1 = c_ctx.wide ? WIDE_LIM1 : NARROW_LIM1;
		if (c_q == '0)             per = 33'd1;
		else if ({1'b0, c_q} > lim1) per = lim1;
		else                       per = {1'b0, c_q};
	end

	logic        v_s3;
	ctx_t        ctx_s3;
	logic [32:0] period_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= c_v;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s3    <= c_ctx;
			period_s3 <= per;
		end
	end

	logic        v_s4;
	ctx_t        ctx_s4;
	logic [32:0] period_s4;
	logic [49:0] prod_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_s3;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s4    <= ctx_s3;
			period_s4 <= period_s3;
			prod_s4   <= 50'(period_s3) * 50'(ctx_s3.duty);
		end
	end

	// compare and result
	logic [33:0] cmp;
	logic [31:0] reload;
	rsp_t        res;
	always_comb begin
		cmp    = prod_s4[49:FRAC_BITS];
		reload = 32'(period_s4 - 33'd1);
		res    = '0;
		res.status = ctx_s4.status;
		if (!ctx_s4.status) begin
			res.prescale_minus_one = 16'(ctx_s4.divider - PSC_W'(1));
			res.reload_value       = reload;
			res.compare_value      = (cmp > {1'b0, period_s4} || cmp[33:32] != 2'b00) ?
				reload : cmp[31:0];
			res.dead_time_ticks    = ctx_s4.dt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rsp_valid <= 1'b0;
		else if (en) rsp_valid <= v_s4;
	end
	always_ff @(posedge clk) begin
		if (en) rsp <= res;
	end

`ifndef SYNTHESIS
	a_stall_only_on_held: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> rsp_valid) else $error("stall without held item");
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status |-> rsp.reload_value == '0 && rsp.compare_value == '0
		&& rsp.prescale_minus_one == '0 && rsp.dead_time_ticks == '0)
		else $error("invalid item with nonzero fields");
	a_cmp_le_reload: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.status |-> rsp.compare_value <= rsp.reload_value + 32'd1
		|| rsp.reload_value == 32'hFFFF_FFFF) else $error("compare above period");
	a_wide_psc: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && !ctx_s4.status && ctx_s4.wide |-> ctx_s4.divider == PSC_W'(1))
		else $error("wide counter needs no prescaler");
`endif
endmodule
`default_nettype wire

[tb/sv/tb_pwm_period_duty_calc_core.sv]
// Testbench for pwm_period_duty_calc_core: drives directed and random PWM requests
// in bursts, predicts prescaler, reload, compare and dead time, and checks every
// result. Depends on pwmc_pkg and the core RTL.
`timescale 1ns / 100ps
module tb_pwm_period_duty_calc_core;
	import pwmc_pkg::*;

	localparam int LATENCY = 101;
	localparam longint CYCLE_LIMIT = 2000000;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [31:0] cfg_data;

	pwm_period_duty_calc_core dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// shadow of the configuration registers
	logic [31:0] clock_hz;
	logic        wide_cnt;
	logic        adv_tim;

	req_t   pending_reqs[$];
	rsp_t   expected_timings[$];
	int     mismatches;
	longint cycles;
	int     burst_left;
	int     gap_left;
	int     hold_left;
	bit     sender_pause;
	int     stall_mode;

	function automatic rsp_t calc_timing(req_t r);
		rsp_t o;
		logic [63:0] lim, div, ticks, per, cmp, dt;
		o = '0;
		if (r.frequency_hz == 0) begin
			o.status = 1'b1;
			return o;
		end
		lim = wide_cnt ? 64'hFFFF_FFFF : 64'(NARROW_COUNTER_MAX);
		div = (64'(clock_hz) / 64'(r.frequency_hz) + lim) / (lim + 1);
		if (div < 1)
			div = 1;
		else if (div > 64'(PRESCALER_MAX) + 1)
			div = 64'(PRESCALER_MAX) + 1;
		ticks = 64'(clock_hz) / div;
		per = ticks / 64'(r.frequency_hz);
		if (per < 1)
			per = 1;
		else if (per > lim + 1)
			per = lim + 1;
		cmp = (per * 64'(r.duty)) >> FRAC_BITS;
		if (cmp > per || cmp > 64'hFFFF_FFFF)
			cmp = per - 1;
		if (adv_tim) begin
			dt = 64'(r.dead_time) >> FRAC_BITS;
			if (dt > 64'(DEAD_TIME_MAX))
				dt = 64'(DEAD_TIME_MAX);
		end else begin
			dt = 0;
		end
		o.status = 1'b0;
		o.prescale_minus_one = 16'(div - 1);
		o.reload_value = 32'(per - 1);
		o.compare_value = 32'(cmp);
		o.dead_time_ticks = 8'(dt);
		return o;
	endfunction

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else if (req_valid && req_stall) begin
			// hold the offered item
		end else begin
			if (req_valid && !req_stall) begin
				expected_timings.push_back(calc_timing(req));
				void'(pending_reqs.pop_front());
			end
			if (sender_pause || pending_reqs.size() == 0) begin
				req_valid <= 1'b0;
			end else if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				req_valid <= 1'b0;
			end else if (burst_left == 0) begin
				burst_left <= $urandom_range(1, 40);
				gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				req_valid <= 1'b0;
			end else begin
				burst_left <= burst_left - 1;
				req_valid <= 1'b1;
				req <= pending_reqs[0];
			end
		end
	end

	// receiver stall pattern and long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp_stall <= 1'b1;
		end else begin
			case (stall_mode)
				0: rsp_stall <= 1'b0;
				1: rsp_stall <= ($urandom_range(0, 3) == 0);
				2: rsp_stall <= ($urandom_range(0, 3) != 0);
				default: rsp_stall <= (cycles[2:0] == 3'd5);
			endcase
		end
	end

	// monitor
	always @(posedge clk) begin
		rsp_t e;
		if (arst_n) begin
			cycles <= cycles + 1;
			if (rsp_valid && !rsp_stall) begin
				if (expected_timings.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result %h", rsp);
				end else begin
					e = expected_timings.pop_front();
					if (rsp.status !== e.status ||
							rsp.prescale_minus_one !== e.prescale_minus_one ||
							rsp.reload_value !== e.reload_value ||
							rsp.compare_value !== e.compare_value ||
							rsp.dead_time_ticks !== e.dead_time_ticks) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp st=%0d psc=%0d rld=%0d cmp=%0d dt=%0d got st=%0d psc=%0d rld=%0d cmp=%0d dt=%0d",
								e.status, e.prescale_minus_one, e.reload_value,
								e.compare_value, e.dead_time_ticks, rsp.status,
								rsp.prescale_minus_one, rsp.reload_value,
								rsp.compare_value, rsp.dead_time_ticks);
					end
				end
			end
			if (cycles > CYCLE_LIMIT) begin
				$display("timeout");
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_TIMER_CLOCK: clock_hz = val;
			REG_COUNTER_WIDE: wide_cnt = val[0];
			REG_ADVANCED_TIMER: adv_tim = val[0];
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		while (pending_reqs.size() != 0 || req_valid || expected_timings.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	function automatic req_t make_req(logic [31:0] f, logic [16:0] d, logic [31:0] t);
		req_t r;
		r.frequency_hz = f;
		r.duty = d;
		r.dead_time = t;
		return r;
	endfunction

	function automatic logic [31:0] rand_freq();
		case ($urandom_range(0, 5))
			0: return $urandom_range(1, 100);
			1: return $urandom_range(1, 5000);
			2: return $urandom_range(1000, 200000);
			3: return $urandom_range(0, 3) == 0 ? 32'd0 : $urandom();
			4: return clock_hz >> $urandom_range(0, 31);
			default: return $urandom_range(1, 50000000);
		endcase
	endfunction

	function automatic logic [16:0] rand_duty();
		case ($urandom_range(0, 4))
			0: return 17'd65536;
			1: return 17'($urandom_range(0, 131071));
			default: return 17'($urandom_range(0, 65536));
		endcase
	endfunction

	function automatic logic [31:0] rand_dead();
		return ($urandom_range(0, 1) == 0) ? $urandom() : 32'($urandom_range(0, 300 << 16));
	endfunction

	initial begin
		logic [31:0] clocks[6];
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cycles = 0;
		mismatches = 0;
		hold_left = 0;
		sender_pause = 1'b0;
		stall_mode = 0;
		clock_hz = 32'd160000000;
		wide_cnt = 1'b0;
		adv_tim = 1'b1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset configuration
		pending_reqs.push_back(make_req(32'd0, 17'd65536, 32'hFFFF_FFFF));
		pending_reqs.push_back(make_req(32'd1, 17'd0, 32'd0));
		pending_reqs.push_back(make_req(32'd1, 17'd65536, 32'h00FF_FFFF));
		pending_reqs.push_back(make_req(32'hFFFF_FFFF, 17'h1FFFF, 32'hFFFF_FFFF));
		pending_reqs.push_back(make_req(32'd20000, 17'd32768, 32'h0010_8000));
		pending_reqs.push_back(make_req(32'd2441, 17'h1FFFF, 32'h0100_0000));
		pending_reqs.push_back(make_req(32'd160000000, 17'd1, 32'h0000_FFFF));
		pending_reqs.push_back(make_req(32'd3, 17'd65535, 32'd65536));
		wait_drained();
		write_reg(REG_COUNTER_WIDE, 32'd1);
		write_reg(REG_ADVANCED_TIMER, 32'd0);
		pending_reqs.push_back(make_req(32'd1, 17'd65536, 32'h00FF_0000));
		pending_reqs.push_back(make_req(32'd1, 17'h1FFFF, 32'hFFFF_FFFF));
		pending_reqs.push_back(make_req(32'd0, 17'd0, 32'd0));
		pending_reqs.push_back(make_req(32'd7, 17'd40000, 32'h0003_0000));
		wait_drained();
		write_reg(REG_TIMER_CLOCK, 32'hFFFF_FFFF);
		pending_reqs.push_back(make_req(32'd1, 17'd65536, 32'd0));
		pending_reqs.push_back(make_req(32'd1, 17'h1FFFF, 32'd0));
		pending_reqs.push_back(make_req(32'hFFFF_FFFF, 17'd65536, 32'd0));
		wait_drained();
		write_reg(REG_COUNTER_WIDE, 32'd0);
		write_reg(REG_TIMER_CLOCK, 32'd1);
		pending_reqs.push_back(make_req(32'd1, 17'd65536, 32'd0));
		pending_reqs.push_back(make_req(32'd2, 17'd32768, 32'd0));
		wait_drained();
		write_reg(REG_TIMER_CLOCK, 32'd0);
		pending_reqs.push_back(make_req(32'd5, 17'd65536, 32'd0));
		wait_drained();
		write_reg(REG_ADVANCED_TIMER, 32'd1);
		write_reg(REG_TIMER_CLOCK, 32'hFFFF_FFFF);
		pending_reqs.push_back(make_req(32'd1, 17'd65536, 32'hABCD_0000));
		wait_drained();

		// random phases over several settings
		clocks = '{32'd160000000, 32'hFFFF_FFFF, 32'd1, 32'd72000000, 32'd1000, 32'd0};
		for (int ph = 0; ph < 11; ph++) begin
			write_reg(REG_TIMER_CLOCK, (ph < 6) ? clocks[ph] : $urandom());
			write_reg(REG_COUNTER_WIDE, 32'($urandom_range(0, 1)));
			write_reg(REG_ADVANCED_TIMER, 32'($urandom_range(0, 1)));
			stall_mode = ph % 4;
			for (int i = 0; i < 150; i++)
				pending_reqs.push_back(make_req(rand_freq(), rand_duty(), rand_dead()));
			if (ph == 3) begin
				@(posedge clk);
				hold_left = 400;
			end
			if (ph == 6) begin
				while (pending_reqs.size() > 75) @(posedge clk);
				sender_pause = 1'b1;
				while (expected_timings.size() != 0) @(posedge clk);
				sender_pause = 1'b0;
			end
			wait_drained();
		end

		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule

[filelist.f]
rtl/pwmc_pkg.sv
rtl/pwmc_div.sv
rtl/pwm_period_duty_calc_core.sv
tb/sv/tb_pwm_period_duty_calc_core.sv
